[hdl/projectile_drag_euler_step_defines.svh]
// Assertion macros shared by the projectile drag Euler step RTL.
// No dependencies; taken in by files that carry assertions.
`ifndef PROJECTILE_DRAG_EULER_STEP_DEFINES_SVH
`define PROJECTILE_DRAG_EULER_STEP_DEFINES_SVH

// same-cycle implication
`define PDES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PDES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pdes_pkg.sv]
// Package for the projectile drag Euler step: widths, codes, types,
// reset values and fixed-point helper functions. No dependencies.
package pdes_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS     = 16;
    localparam int GRAV_BITS     = 24;
    localparam int DRAG_BITS     = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    typedef logic signed [WORD_BITS-1:0] t_word;

    localparam t_word MAXW = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word MINW = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam logic [GRAV_BITS-1:0] RST_GRAVITY  = GRAV_BITS'(642253);
    localparam logic [DRAG_BITS-1:0] RST_DRAG     = DRAG_BITS'(257);
    localparam t_word                RST_WIND     = t_word'(-131072);
    localparam t_word                RST_START_X  = t_word'(0);
    localparam t_word                RST_START_Z  = t_word'(262144000);
    localparam t_word                RST_START_VX = t_word'(2621440);
    localparam t_word                RST_START_VY = t_word'(0);
    localparam t_word                RST_START_VZ = t_word'(0);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GRAVITY_STEP  = 3'd0,
        CFG_DRAG_PER_MASS = 3'd1,
        CFG_WIND_DRIFT    = 3'd2,
        CFG_START_X       = 3'd3,
        CFG_START_Z       = 3'd4,
        CFG_START_VX      = 3'd5,
        CFG_START_VY      = 3'd6,
        CFG_START_VZ      = 3'd7
    } t_cfg_reg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_Z,
        S_SUM,
        S_ROOT,
        S_DRAG,
        S_KROUND,
        S_AMUL,
        S_AROUND,
        S_GRAV,
        S_VUPD,
        S_PX,
        S_WIND,
        S_PY,
        S_PZ,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } t_axis;

    typedef struct packed {
        logic [GRAV_BITS-1:0] gravity_step;
        logic [DRAG_BITS-1:0] drag_per_mass;
        t_word                wind_drift;
        t_word                start_x;
        t_word                start_z;
        t_word                start_vx;
        t_word                start_vy;
        t_word                start_vz;
    } t_cfg;

    typedef struct packed {
        t_word pos_x;
        t_word pos_y;
        t_word pos_z;
        t_word vel_x;
        t_word vel_y;
        t_word vel_z;
        logic  saturated;
    } t_res;

    typedef struct packed {
        logic  sat;
        t_word val;
    } t_sat_word;

    function automatic logic [WORD_BITS-1:0] mag(input t_word a);
        mag = a[WORD_BITS-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic t_sat_word sat_add(input t_word a, input t_word b);
        logic [WORD_BITS:0] s;
        t_sat_word          r;
        s     = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        r.sat = s[WORD_BITS] != s[WORD_BITS-1];
        if (r.sat) begin
            r.val = s[WORD_BITS] ? MINW : MAXW;
        end else begin
            r.val = s[WORD_BITS-1:0];
        end
        return r;
    endfunction

    // round magnitude product to nearest (ties away), apply sign, clip
    function automatic t_sat_word mulq_round(input logic [2*WORD_BITS-1:0] p,
                                             input logic neg);
        logic [2*WORD_BITS-1:0]           q;
        logic [WORD_BITS-FRAC_BITS:0]     hi;
        logic [WORD_BITS-2:0]             lo;
        t_sat_word                        r;
        q  = p + {{(2*WORD_BITS-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
        hi = q[2*WORD_BITS-1:WORD_BITS-1+FRAC_BITS];
        lo = q[WORD_BITS-2+FRAC_BITS:FRAC_BITS];
        if (!neg) begin
            r.sat = hi != '0;
            r.val = r.sat ? MAXW : t_word'({1'b0, lo});
        end else if (hi == '0) begin
            r.sat = 1'b0;
            r.val = -t_word'({1'b0, lo});
        end else begin
            r.sat = !(hi == {{(WORD_BITS-FRAC_BITS){1'b0}}, 1'b1} && lo == '0);
            r.val = MINW;
        end
        return r;
    endfunction

endpackage

[hdl/pdes_if.sv]
// Channel interfaces: tick input, state result and register write.
// Depends on pdes_pkg.
interface pdes_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source(output valid, output restart, input ready);
    modport sink(input valid, input restart, output ready);
endinterface

interface pdes_out_if;
    logic                  valid;
    logic                  ready;
    pdes_pkg::t_word       pos_x;
    pdes_pkg::t_word       pos_y;
    pdes_pkg::t_word       pos_z;
    pdes_pkg::t_word       vel_x;
    pdes_pkg::t_word       vel_y;
    pdes_pkg::t_word       vel_z;
    logic                  saturated;

    modport source(output valid, output pos_x, output pos_y, output pos_z,
                   output vel_x, output vel_y, output vel_z, output saturated,
                   input ready);
    modport sink(input valid, input pos_x, input pos_y, input pos_z,
                 input vel_x, input vel_y, input vel_z, input saturated,
                 output ready);
endinterface

interface pdes_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [pdes_pkg::CFG_IDX_BITS-1:0]     index;
    logic [pdes_pkg::CFG_DATA_BITS-1:0]    data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

[hdl/pdes_sqrt.sv]
// Iterative floor square root, one result bit per cycle.
// Depends on pdes_pkg.
module pdes_sqrt (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [2*pdes_pkg::WORD_BITS-1:0]    i_rad,
    output logic                                o_done,
    output logic [pdes_pkg::WORD_BITS-1:0]      o_root
);
    localparam int W        = pdes_pkg::WORD_BITS;
    localparam int CNT_BITS = $clog2(W);

    logic [2*W-1:0]    r_rad, n_rad;
    logic [W:0]        r_rem, n_rem;
    logic [W-1:0]      r_root, n_root;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [W+2:0]      cand;
    logic [W+2:0]      trial;
    logic              ge;

    always_comb begin
        cand   = {r_rem, r_rad[2*W-1:2*W-2]};
        trial  = {1'b0, r_root, 2'b01};
        ge     = cand >= trial;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rad  = i_rad;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = CNT_BITS'(W-1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad  = {r_rad[2*W-3:0], 2'b00};
            n_rem  = ge ? (W+1)'(cand - trial) : (W+1)'(cand);
            n_root = {r_root[W-2:0], ge};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_cnt  <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

[hdl/pdes_engine.sv]
// Step sequencer with the shared multiplier and saturating adder; holds
// the point-mass state. Depends on pdes_pkg, pdes_sqrt and projectile_drag_euler_step_defines.svh.
`include "projectile_drag_euler_step_defines.svh"

module pdes_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_restart,
    input  pdes_pkg::t_cfg     i_cfg,
    input  logic               i_out_free,
    output logic               o_idle,
    output logic               o_done,
    output pdes_pkg::t_res     o_res
);
    localparam int W = pdes_pkg::WORD_BITS;

    pdes_pkg::t_state  r_state, n_state;
    pdes_pkg::t_axis   r_axis, n_axis;
    logic              r_sat, n_sat;
    pdes_pkg::t_word   r_px, n_px, r_py, n_py, r_pz, n_pz;
    pdes_pkg::t_word   r_vx, n_vx, r_vy, n_vy, r_vz, n_vz;
    logic [2*W-1:0]    r_prod, n_prod;
    logic [2*W-1:0]    r_acc, n_acc;
    pdes_pkg::t_word   r_speed, n_speed;
    pdes_pkg::t_word   r_k, n_k;
    pdes_pkg::t_word   r_a, n_a;

    logic [W-1:0]        mul_a, mul_b;
    pdes_pkg::t_word     add_a, add_b;
    pdes_pkg::t_sat_word add_res;
    pdes_pkg::t_sat_word mq_res;
    pdes_pkg::t_word     v_sel;
    pdes_pkg::t_word     neg_g;
    logic                sqrt_start;
    logic                sqrt_done;
    logic [W-1:0]        sqrt_root;

    pdes_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (r_acc + r_prod),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    always_comb begin
        case (r_axis)
            pdes_pkg::AX_X: v_sel = r_vx;
            pdes_pkg::AX_Y: v_sel = r_vy;
            pdes_pkg::AX_Z: v_sel = r_vz;
            default:        v_sel = r_vz;
        endcase
        neg_g = pdes_pkg::t_word'(-$signed({1'b0, i_cfg.gravity_step}));

        mul_a = '0;
        mul_b = '0;
        add_a = r_a;
        add_b = r_a;
        case (r_state)
            pdes_pkg::S_SQ_X: begin
                mul_a = pdes_pkg::mag(r_vx);
                mul_b = pdes_pkg::mag(r_vx);
            end
            pdes_pkg::S_SQ_Y: begin
                mul_a = pdes_pkg::mag(r_vy);
                mul_b = pdes_pkg::mag(r_vy);
            end
            pdes_pkg::S_SQ_Z: begin
                mul_a = pdes_pkg::mag(r_vz);
                mul_b = pdes_pkg::mag(r_vz);
            end
            pdes_pkg::S_DRAG: begin
                mul_a = r_speed;
                mul_b = W'(i_cfg.drag_per_mass);
            end
            pdes_pkg::S_AMUL: begin
                mul_a = pdes_pkg::mag(v_sel);
                mul_b = r_k;
            end
            pdes_pkg::S_GRAV: begin
                add_a = r_a;
                add_b = neg_g;
            end
            pdes_pkg::S_VUPD: begin
                add_a = v_sel;
                add_b = r_a;
            end
            pdes_pkg::S_PX: begin
                add_a = r_px;
                add_b = r_vx;
            end
            pdes_pkg::S_WIND: begin
                add_a = r_px;
                add_b = i_cfg.wind_drift;
            end
            pdes_pkg::S_PY: begin
                add_a = r_py;
                add_b = r_vy;
            end
            pdes_pkg::S_PZ: begin
                add_a = r_pz;
                add_b = r_vz;
            end
            default: begin
                mul_a = '0;
            end
        endcase
        add_res = pdes_pkg::sat_add(add_a, add_b);
        mq_res  = pdes_pkg::mulq_round(r_prod,
                                       (r_state == pdes_pkg::S_AROUND) && !v_sel[W-1]);
    end

    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_sat      = r_sat;
        n_px       = r_px;
        n_py       = r_py;
        n_pz       = r_pz;
        n_vx       = r_vx;
        n_vy       = r_vy;
        n_vz       = r_vz;
        n_prod     = (2*W)'(mul_a) * (2*W)'(mul_b);
        n_acc      = r_acc;
        n_speed    = r_speed;
        n_k        = r_k;
        n_a        = r_a;
        sqrt_start = 1'b0;
        o_done     = 1'b0;
        case (r_state)
            pdes_pkg::S_IDLE: begin
                if (i_start) begin
                    n_sat = 1'b0;
                    if (i_restart) begin
                        n_px    = i_cfg.start_x;
                        n_py    = '0;
                        n_pz    = i_cfg.start_z;
                        n_vx    = i_cfg.start_vx;
                        n_vy    = i_cfg.start_vy;
                        n_vz    = i_cfg.start_vz;
                        n_state = pdes_pkg::S_DONE;
                    end else begin
                        n_state = pdes_pkg::S_SQ_X;
                    end
                end
            end
            pdes_pkg::S_SQ_X: n_state = pdes_pkg::S_SQ_Y;
            pdes_pkg::S_SQ_Y: begin
                n_acc   = r_prod;
                n_state = pdes_pkg::S_SQ_Z;
            end
            pdes_pkg::S_SQ_Z: begin
                n_acc   = r_acc + r_prod;
                n_state = pdes_pkg::S_SUM;
            end
            pdes_pkg::S_SUM: begin
                sqrt_start = 1'b1;
                n_state    = pdes_pkg::S_ROOT;
            end
            pdes_pkg::S_ROOT: begin
                if (sqrt_done) begin
                    n_speed = sqrt_root[W-1] ? pdes_pkg::MAXW : sqrt_root;
                    n_sat   = r_sat | sqrt_root[W-1];
                    n_state = pdes_pkg::S_DRAG;
                end
            end
            pdes_pkg::S_DRAG: n_state = pdes_pkg::S_KROUND;
            pdes_pkg::S_KROUND: begin
                n_k     = mq_res.val;
                n_sat   = r_sat | mq_res.sat;
                n_axis  = pdes_pkg::AX_X;
                n_state = pdes_pkg::S_AMUL;
            end
            pdes_pkg::S_AMUL: n_state = pdes_pkg::S_AROUND;
            pdes_pkg::S_AROUND: begin
                n_a     = mq_res.val;
                n_sat   = r_sat | mq_res.sat;
                n_state = (r_axis == pdes_pkg::AX_Z) ? pdes_pkg::S_GRAV : pdes_pkg::S_VUPD;
            end
            pdes_pkg::S_GRAV: begin
                n_a     = add_res.val;
                n_sat   = r_sat | add_res.sat;
                n_state = pdes_pkg::S_VUPD;
            end
            pdes_pkg::S_VUPD: begin
                n_sat = r_sat | add_res.sat;
                case (r_axis)
                    pdes_pkg::AX_X: begin
                        n_vx    = add_res.val;
                        n_axis  = pdes_pkg::AX_Y;
                        n_state = pdes_pkg::S_AMUL;
                    end
                    pdes_pkg::AX_Y: begin
                        n_vy    = add_res.val;
                        n_axis  = pdes_pkg::AX_Z;
                        n_state = pdes_pkg::S_AMUL;
                    end
                    default: begin
                        n_vz    = add_res.val;
                        n_state = pdes_pkg::S_PX;
                    end
                endcase
            end
            pdes_pkg::S_PX: begin
                n_px    = add_res.val;
                n_sat   = r_sat | add_res.sat;
                n_state = pdes_pkg::S_WIND;
            end
            pdes_pkg::S_WIND: begin
                n_px    = add_res.val;
                n_sat   = r_sat | add_res.sat;
                n_state = pdes_pkg::S_PY;
            end
            pdes_pkg::S_PY: begin
                n_py    = add_res.val;
                n_sat   = r_sat | add_res.sat;
                n_state = pdes_pkg::S_PZ;
            end
            pdes_pkg::S_PZ: begin
                n_pz    = add_res.val;
                n_sat   = r_sat | add_res.sat;
                n_state = pdes_pkg::S_DONE;
            end
            pdes_pkg::S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = pdes_pkg::S_IDLE;
                end
            end
            default: n_state = pdes_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_speed <= n_speed;
        r_k     <= n_k;
        r_a     <= n_a;
        r_axis  <= n_axis;
        if (!i_rst_n) begin
            r_state <= pdes_pkg::S_IDLE;
            r_sat   <= 1'b0;
            r_px    <= pdes_pkg::RST_START_X;
            r_py    <= '0;
            r_pz    <= pdes_pkg::RST_START_Z;
            r_vx    <= pdes_pkg::RST_START_VX;
            r_vy    <= pdes_pkg::RST_START_VY;
            r_vz    <= pdes_pkg::RST_START_VZ;
        end else begin
            r_state <= n_state;
            r_sat   <= n_sat;
            r_px    <= n_px;
            r_py    <= n_py;
            r_pz    <= n_pz;
            r_vx    <= n_vx;
            r_vy    <= n_vy;
            r_vz    <= n_vz;
        end
    end

    assign o_idle          = r_state == pdes_pkg::S_IDLE;
    assign o_res.pos_x     = r_px;
    assign o_res.pos_y     = r_py;
    assign o_res.pos_z     = r_pz;
    assign o_res.vel_x     = r_vx;
    assign o_res.vel_y     = r_vy;
    assign o_res.vel_z     = r_vz;
    assign o_res.saturated = r_sat;

    `PDES_ASSERT_NEXT(a_restart_load, i_clk, i_rst_n,
        r_state == pdes_pkg::S_IDLE && i_start && i_restart,
        r_state == pdes_pkg::S_DONE && !r_sat && r_py == '0,
        "restart did not load the start state")
    `PDES_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done,
        r_state == pdes_pkg::S_IDLE, "sequencer not idle after handing over word")
    `PDES_ASSERT_NOW(a_root_wait, i_clk, i_rst_n, sqrt_done,
        r_state == pdes_pkg::S_ROOT, "square root finished outside its wait state")
    `PDES_ASSERT_NEXT(a_axis_step, i_clk, i_rst_n,
        r_state == pdes_pkg::S_VUPD && r_axis != pdes_pkg::AX_Z,
        r_state == pdes_pkg::S_AMUL, "velocity update skipped an axis")
endmodule

[hdl/projectile_drag_euler_step.sv]
// A restart word loads the start state and goes straight to the done state; a step word runs
// the sequencer, which waits on the 32-step bit-serial square root and otherwise drives the
// shared multiplier and adder. A result is handed over once the output register is free.
// Input is ready again in the same cycle that a result is presented, and a new word is taken
// while a result waits; the engine stalls in its done state while an unread result is held.
// Reset (synchronous, active low) loads register reset values and start state.
module projectile_drag_euler_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdes_in_if.sink     i_in,
    pdes_out_if.source  o_out,
    pdes_cfg_if.sink    i_cfg
);
    pdes_pkg::t_cfg  r_cfg, n_cfg;
    logic            r_ovalid, n_ovalid;
    pdes_pkg::t_res  r_ores, n_ores;
    logic            eng_idle;
    logic            eng_done;
    logic            out_free;
    pdes_pkg::t_res  eng_res;

    assign out_free    = !r_ovalid || o_out.ready;
    assign i_in.ready  = eng_idle;
    assign i_cfg.ready = 1'b1;

    pdes_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in.valid && eng_idle),
        .i_restart  (i_in.restart),
        .i_cfg      (r_cfg),
        .i_out_free (out_free),
        .o_idle     (eng_idle),
        .o_done     (eng_done),
        .o_res      (eng_res)
    );

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (pdes_pkg::t_cfg_reg'(i_cfg.index))
                pdes_pkg::CFG_GRAVITY_STEP:
                    n_cfg.gravity_step = i_cfg.data[pdes_pkg::GRAV_BITS-1:0];
                pdes_pkg::CFG_DRAG_PER_MASS:
                    n_cfg.drag_per_mass = i_cfg.data[pdes_pkg::DRAG_BITS-1:0];
                pdes_pkg::CFG_WIND_DRIFT: n_cfg.wind_drift = i_cfg.data;
                pdes_pkg::CFG_START_X:    n_cfg.start_x    = i_cfg.data;
                pdes_pkg::CFG_START_Z:    n_cfg.start_z    = i_cfg.data;
                pdes_pkg::CFG_START_VX:   n_cfg.start_vx   = i_cfg.data;
                pdes_pkg::CFG_START_VY:   n_cfg.start_vy   = i_cfg.data;
                pdes_pkg::CFG_START_VZ:   n_cfg.start_vz   = i_cfg.data;
                default:                  n_cfg = r_cfg;
            endcase
        end

        n_ovalid = r_ovalid;
        n_ores   = r_ores;
        if (eng_done) begin
            n_ovalid = 1'b1;
            n_ores   = eng_res;
        end else if (o_out.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ores <= n_ores;
        if (!i_rst_n) begin
            r_cfg.gravity_step  <= pdes_pkg::RST_GRAVITY;
            r_cfg.drag_per_mass <= pdes_pkg::RST_DRAG;
            r_cfg.wind_drift    <= pdes_pkg::RST_WIND;
            r_cfg.start_x       <= pdes_pkg::RST_START_X;
            r_cfg.start_z       <= pdes_pkg::RST_START_Z;
            r_cfg.start_vx      <= pdes_pkg::RST_START_VX;
            r_cfg.start_vy      <= pdes_pkg::RST_START_VY;
            r_cfg.start_vz      <= pdes_pkg::RST_START_VZ;
            r_ovalid            <= 1'b0;
        end else begin
            r_cfg    <= n_cfg;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.pos_x     = r_ores.pos_x;
    assign o_out.pos_y     = r_ores.pos_y;
    assign o_out.pos_z     = r_ores.pos_z;
    assign o_out.vel_x     = r_ores.vel_x;
    assign o_out.vel_y     = r_ores.vel_y;
    assign o_out.vel_z     = r_ores.vel_z;
    assign o_out.saturated = r_ores.saturated;
endmodule

[test/tb_projectile_drag_euler_step.sv]
// Self-checking testbench for projectile_drag_euler_step: a directed table, then random
// flight phases under random idling, checked against a fixed-point Euler predictor.
// Depends on pdes_pkg, the channel interfaces in pdes_if and the block itself.
module tb_projectile_drag_euler_step;
    timeunit 1ns;
    timeprecision 1ps;

    import pdes_pkg::*;

    localparam int ITEM_TARGET = 1850;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 120;
    localparam int PRINT_LIMIT = 60;

    typedef enum logic [1:0] {
        ROW_SET,
        ROW_TICK,
        ROW_CHECK
    } t_row_kind;

    typedef struct {
        t_row_kind kind;
        logic      restart;
        t_res      want;
        t_cfg      regs;
    } t_row;

    localparam t_cfg RESET_REGS = t_cfg'{RST_GRAVITY, RST_DRAG, RST_WIND, RST_START_X,
                                         RST_START_Z, RST_START_VX, RST_START_VY,
                                         RST_START_VZ};
    localparam t_res RESET_STATE = t_res'{RST_START_X, 32'sd0, RST_START_Z, RST_START_VX,
                                          RST_START_VY, RST_START_VZ, 1'b0};
    localparam t_word X0 = 32'sh0064_0000;
    localparam t_word Z0 = 32'sh0032_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pdes_in_if  in_ch();
    pdes_out_if out_ch();
    pdes_cfg_if cfg_ch();

    projectile_drag_euler_step u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #10 i_clk = ~i_clk;

    t_cfg  cfg_shadow = RESET_REGS;
    t_word fly_px, fly_py, fly_pz, fly_vx, fly_vy, fly_vz;
    logic  step_clipped;

    t_res pending_states[$];
    t_row rows[$];
    int   ticks_sent = 0;
    int   results_seen = 0;
    int   fail_count = 0;
    logic calm = 1'b0;
    logic hold_req = 1'b0;

    function automatic t_word clamp(input longint v);
        if (v > longint'(MAXW)) begin
            step_clipped = 1'b1;
            return MAXW;
        end
        if (v < longint'(MINW)) begin
            step_clipped = 1'b1;
            return MINW;
        end
        return t_word'(v);
    endfunction

    function automatic logic [63:0] abs_wide(input t_word a);
        return a[WORD_BITS-1] ? 64'(-longint'(a)) : 64'(longint'(a));
    endfunction

    function automatic t_word qmul(input t_word a, input t_word b, input logic flip);
        logic [63:0] m;
        logic        neg;
        neg = (a[WORD_BITS-1] != b[WORD_BITS-1]) != flip;
        m   = (abs_wide(a) * abs_wide(b) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return clamp(neg ? -longint'(m) : longint'(m));
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    function automatic void reload_start();
        fly_px = cfg_shadow.start_x;
        fly_py = '0;
        fly_pz = cfg_shadow.start_z;
        fly_vx = cfg_shadow.start_vx;
        fly_vy = cfg_shadow.start_vy;
        fly_vz = cfg_shadow.start_vz;
    endfunction

    function automatic t_res advance_flight(input logic restart_bit);
        logic [63:0] sq;
        t_word       speed, k, ax, ay, az;
        t_res        r;
        step_clipped = 1'b0;
        if (restart_bit) begin
            reload_start();
        end else begin
            sq = abs_wide(fly_vx) * abs_wide(fly_vx) + abs_wide(fly_vy) * abs_wide(fly_vy)
               + abs_wide(fly_vz) * abs_wide(fly_vz);
            speed  = clamp(longint'(floor_root(sq)));
            k      = qmul(speed, t_word'({{(WORD_BITS-DRAG_BITS){1'b0}},
                                          cfg_shadow.drag_per_mass}), 1'b0);
            ax     = qmul(fly_vx, k, 1'b1);
            ay     = qmul(fly_vy, k, 1'b1);
            az     = qmul(fly_vz, k, 1'b1);
            az     = clamp(longint'(az) - longint'(cfg_shadow.gravity_step));
            fly_vx = clamp(longint'(fly_vx) + longint'(ax));
            fly_vy = clamp(longint'(fly_vy) + longint'(ay));
            fly_vz = clamp(longint'(fly_vz) + longint'(az));
            fly_px = clamp(longint'(fly_px) + longint'(fly_vx));
            fly_px = clamp(longint'(fly_px) + longint'(cfg_shadow.wind_drift));
            fly_py = clamp(longint'(fly_py) + longint'(fly_vy));
            fly_pz = clamp(longint'(fly_pz) + longint'(fly_vz));
        end
        r.pos_x     = fly_px;
        r.pos_y     = fly_py;
        r.pos_z     = fly_pz;
        r.vel_x     = fly_vx;
        r.vel_y     = fly_vy;
        r.vel_z     = fly_vz;
        r.saturated = step_clipped;
        return r;
    endfunction

    function automatic logic [31:0] corner_word();
        case ($urandom_range(3))
            0: return MINW;
            1: return MAXW;
            2: return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_cfg pick_setting();
        t_cfg        c;
        int unsigned mode;
        mode = $urandom_range(9);
        if (mode < 6) begin
            c.gravity_step  = GRAV_BITS'($urandom_range(0, 1 << 21));
            c.drag_per_mass = DRAG_BITS'($urandom_range(0, 2000));
            c.wind_drift    = t_word'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
            c.start_x       = t_word'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
            c.start_z       = t_word'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
            c.start_vx      = t_word'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
            c.start_vy      = t_word'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
            c.start_vz      = t_word'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
        end else if (mode < 8) begin
            c.gravity_step  = GRAV_BITS'(corner_word());
            c.drag_per_mass = DRAG_BITS'(corner_word());
            c.wind_drift    = corner_word();
            c.start_x       = corner_word();
            c.start_z       = corner_word();
            c.start_vx      = corner_word();
            c.start_vy      = corner_word();
            c.start_vz      = corner_word();
        end else begin
            c.gravity_step  = GRAV_BITS'($urandom());
            c.drag_per_mass = DRAG_BITS'($urandom());
            c.wind_drift    = $urandom();
            c.start_x       = $urandom();
            c.start_z       = $urandom();
            c.start_vx      = $urandom();
            c.start_vy      = $urandom();
            c.start_vz      = $urandom();
        end
        return c;
    endfunction

    function automatic t_row row_set(input t_cfg c);
        t_row r;
        r.kind    = ROW_SET;
        r.restart = 1'b0;
        r.want    = '0;
        r.regs    = c;
        return r;
    endfunction

    function automatic t_row row_tick(input logic rs);
        t_row r;
        r.kind    = ROW_TICK;
        r.restart = rs;
        r.want    = '0;
        r.regs    = '0;
        return r;
    endfunction

    function automatic t_row row_check(input logic rs, input t_res w);
        t_row r;
        r.kind    = ROW_CHECK;
        r.restart = rs;
        r.want    = w;
        r.regs    = '0;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("mismatch %s: got %h want %h (word %0d)", what, got, want, results_seen);
    endtask

    task automatic check_result();
        t_res want;
        results_seen++;
        if (pending_states.size() == 0) begin
            report("unexpected word", out_ch.pos_x, '0);
            return;
        end
        want = pending_states.pop_front();
        if (out_ch.pos_x !== want.pos_x) report("pos_x", out_ch.pos_x, want.pos_x);
        if (out_ch.pos_y !== want.pos_y) report("pos_y", out_ch.pos_y, want.pos_y);
        if (out_ch.pos_z !== want.pos_z) report("pos_z", out_ch.pos_z, want.pos_z);
        if (out_ch.vel_x !== want.vel_x) report("vel_x", out_ch.vel_x, want.vel_x);
        if (out_ch.vel_y !== want.vel_y) report("vel_y", out_ch.vel_y, want.vel_y);
        if (out_ch.vel_z !== want.vel_z) report("vel_z", out_ch.vel_z, want.vel_z);
        if (out_ch.saturated !== want.saturated)
            report("saturated", 32'(out_ch.saturated), 32'(want.saturated));
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_GRAVITY_STEP:  cfg_shadow.gravity_step  = value[GRAV_BITS-1:0];
            CFG_DRAG_PER_MASS: cfg_shadow.drag_per_mass = value[DRAG_BITS-1:0];
            CFG_WIND_DRIFT:    cfg_shadow.wind_drift    = value;
            CFG_START_X:       cfg_shadow.start_x       = value;
            CFG_START_Z:       cfg_shadow.start_z       = value;
            CFG_START_VX:      cfg_shadow.start_vx      = value;
            CFG_START_VY:      cfg_shadow.start_vy      = value;
            default:           cfg_shadow.start_vz      = value;
        endcase
    endtask

    task automatic program_regs(input t_cfg c);
        write_reg(CFG_GRAVITY_STEP, 32'(c.gravity_step));
        write_reg(CFG_DRAG_PER_MASS, 32'(c.drag_per_mass));
        write_reg(CFG_WIND_DRIFT, c.wind_drift);
        write_reg(CFG_START_X, c.start_x);
        write_reg(CFG_START_Z, c.start_z);
        write_reg(CFG_START_VX, c.start_vx);
        write_reg(CFG_START_VY, c.start_vy);
        write_reg(CFG_START_VZ, c.start_vz);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_states.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic offer_tick(input logic restart_bit, input logic typed, input t_res want);
        t_res predicted;
        if (!calm && $urandom_range(99) < 32) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.restart <= restart_bit;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = advance_flight(restart_bit);
        pending_states.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    initial begin
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) check_result();
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= 32);
            end
        end
    end

    initial begin
        int unsigned run_len;
        int          phase_no;
        in_ch.valid   <= 1'b0;
        in_ch.restart <= 1'b0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CFG_GRAVITY_STEP;
        cfg_ch.data   <= '0;
        reload_start();
        rows = '{
            row_check(1'b1, RESET_STATE),
            row_tick(1'b0), row_tick(1'b0), row_tick(1'b1), row_tick(1'b0),
            row_set(t_cfg'{24'd0, 16'd0, 32'sd0, X0, Z0, 32'sd0, 32'sd0, 32'sd0}),
            row_check(1'b1, t_res'{X0, 32'sd0, Z0, 32'sd0, 32'sd0, 32'sd0, 1'b0}),
            row_check(1'b0, t_res'{X0, 32'sd0, Z0, 32'sd0, 32'sd0, 32'sd0, 1'b0}),
            row_set(t_cfg'{24'hFFFFFF, 16'd0, 32'sd0, X0, Z0, 32'sd0, 32'sd0, 32'sd0}),
            row_tick(1'b1), row_tick(1'b0), row_tick(1'b0),
            row_set(t_cfg'{24'hFFFFFF, 16'hFFFF, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW}),
            row_check(1'b1, t_res'{MAXW, 32'sd0, MAXW, MAXW, MAXW, MAXW, 1'b0}),
            row_tick(1'b0), row_tick(1'b0),
            row_set(t_cfg'{24'd0, 16'd0, MINW, MINW, MINW, MINW, MINW, MINW}),
            row_check(1'b1, t_res'{MINW, 32'sd0, MINW, MINW, MINW, MINW, 1'b0}),
            row_tick(1'b0), row_tick(1'b0),
            row_set(t_cfg'{24'd0, 16'h8000, 32'sd0, 32'sd0, 32'sd0, 32'sh0002_0000,
                           MAXW, 32'sd0}),
            row_tick(1'b1), row_tick(1'b0),
            row_set(RESET_REGS),
            row_check(1'b1, RESET_STATE),
            row_tick(1'b0), row_tick(1'b0), row_tick(1'b0)
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            case (rows[i].kind)
                ROW_SET: begin
                    drain_results();
                    program_regs(rows[i].regs);
                end
                ROW_TICK:  offer_tick(rows[i].restart, 1'b0, '0);
                default:   offer_tick(rows[i].restart, 1'b1, rows[i].want);
            endcase
        end

        phase_no = 0;
        while (ticks_sent < ITEM_TARGET) begin
            drain_results();
            program_regs(pick_setting());
            phase_no++;
            calm = (phase_no == 3);
            run_len = calm ? 200 : $urandom_range(8, 90);
            if ($urandom_range(7) != 0) offer_tick(1'b1, 1'b0, '0);
            for (int n = 0; n < run_len; n++) begin
                if (phase_no == 5 && n == 2) hold_req = 1'b1;
                if (phase_no == 7 && n == run_len / 2) drain_results();
                offer_tick($urandom_range(99) < 4, 1'b0, '0);
            end
        end
        calm = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_projectile_drag_euler_step: PASS");
        end else begin
            $display("tb_projectile_drag_euler_step: FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_projectile_drag_euler_step: FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/pdes_pkg.sv
hdl/pdes_if.sv
hdl/pdes_sqrt.sv
hdl/pdes_engine.sv
hdl/projectile_drag_euler_step.sv
test/tb_projectile_drag_euler_step.sv
